/* sv/skv_pkg.sv */
// Shared types, codes and helper functions for the string key/value table.
// No dependencies; used by skv_cell, string_key_value_table and the bench.
`default_nettype none

package skv_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int VALUE_WORDS_DEF   = 8;
    localparam int NAME_BYTES        = 15;
    localparam int NAME_W            = 120;
    localparam int WORD_W            = 64;
    // wide enough for any table size in the supported range
    localparam int IDX_MAX_W         = 8;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [63:0]       name_lo;
        logic [55:0]       name_hi;
        logic [63:0]       value_word;
        logic [2:0]        word_index;
        logic              last_word;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [63:0]       data_word;
        logic [2:0]        data_index;
        logic              last;
        logic [3:0]        entry_count;
    } out_item_t;

    // search token passed down the cell chain
    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [IDX_MAX_W-1:0] idx;
    } tok_t;

    // keep bytes before the first zero byte, zero the rest
    function automatic logic [NAME_W-1:0] canon_name(input logic [63:0] lo,
                                                     input logic [55:0] hi);
        logic [NAME_W-1:0] raw;
        logic [NAME_W-1:0] r;
        logic              alive;
        raw   = {hi, lo};
        r     = '0;
        alive = 1'b1;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            if (raw[i*8 +: 8] == 8'h00)
                alive = 1'b0;
            if (alive)
                r[i*8 +: 8] = raw[i*8 +: 8];
        end
        return r;
    endfunction

    // one word of the value string; returns {ended_out, word}
    function automatic logic [WORD_W:0] canon_word(input logic [WORD_W-1:0] w,
                                                   input logic ended_in,
                                                   input logic is_last);
        logic [WORD_W-1:0] v;
        logic              ended;
        v     = w;
        ended = ended_in;
        if (is_last)
            v[63:56] = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (ended)
                v[i*8 +: 8] = 8'h00;
            else if (v[i*8 +: 8] == 8'h00)
                ended = 1'b1;
        end
        return {ended, v};
    endfunction

endpackage

`default_nettype wire

/* sv/skv_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module skv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/skv_cell.sv */
// One table slot: holds an entry name, compares it to the search key and
// passes the search token to the next cell. Depends on skv_pkg.
`default_nettype none

module skv_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [skv_pkg::NAME_W-1:0]  key,
    input  logic                        live,
    input  logic                        wr_en,
    input  logic [skv_pkg::NAME_W-1:0]  wr_name,
    input  skv_pkg::tok_t               tok_in,
    output skv_pkg::tok_t               tok_out,
    output logic [skv_pkg::NAME_W-1:0]  name
);
    import skv_pkg::*;

    logic [NAME_W-1:0] name_reg;
    tok_t              tok_reg;
    logic              match;

    assign match   = live && (name_reg == key);
    assign tok_out = tok_reg;
    assign name    = name_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg.valid <= tok_in.valid;
            tok_reg.found <= tok_in.found | match;
            // first hit wins
            tok_reg.idx   <= tok_in.found ? tok_in.idx : IDX_MAX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            name_reg <= wr_name;
    end

endmodule

`default_nettype wire

/* sv/string_key_value_table.sv */
// String key/value table: names in a chain of compare cells, values in a RAM.
// Depends on skv_pkg, skv_cell, skv_ram.
//
//   channel | signals                  | direction | carries
//   cmd     | cmd_valid/cmd_ready/cmd  | in        | in_item_t (add/remove/lookup)
//   rsp     | rsp_valid/rsp_ready/rsp  | out       | out_item_t (status, words)
//
// An add word without last mark is only staged. Searches walk the cell chain,
// one cell per cycle. Add commit writes VALUE_WORDS words to the RAM; remove
// reads and then writes each moved word; lookup reads each word, then returns it.
// Reset clears the count and staged words; no clearing pass.
// A stalled rsp holds the sequencer before it loads the next result.
`default_nettype none

module string_key_value_table #(
    parameter int TABLE_ENTRIES = skv_pkg::TABLE_ENTRIES_DEF,
    parameter int VALUE_WORDS   = skv_pkg::VALUE_WORDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  skv_pkg::in_item_t   cmd,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output skv_pkg::out_item_t  rsp
);
    import skv_pkg::*;

    localparam int IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW    = $clog2(TABLE_ENTRIES + 1);
    localparam int WIW   = (VALUE_WORDS > 1) ? $clog2(VALUE_WORDS) : 1;
    localparam int DEPTH = TABLE_ENTRIES * VALUE_WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = (VALUE_WORDS < 8) ? VALUE_WORDS : 8;

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_ACT, S_COPY, S_MRD, S_MWR, S_LRD, S_LOUT, S_RESP
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       count_reg;
    logic [WORD_W-1:0]   staged_reg [VALUE_WORDS];
    logic [NAME_W-1:0]   key_reg;
    logic [1:0]          op_reg;
    logic                start_reg;
    logic                hit_found_reg;
    logic [IW-1:0]       hit_idx_reg;
    logic [IW-1:0]       dst_reg;
    logic [IW-1:0]       src_reg;
    logic [WIW-1:0]      word_reg;
    logic                ended_reg;
    logic [1:0]          status_reg;
    logic                rsp_valid_reg;
    out_item_t           rsp_reg;

    tok_t                tok [TABLE_ENTRIES+1];
    logic [NAME_W-1:0]   cell_name [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] cell_we;
    logic [NAME_W-1:0]   cell_wdata;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;

    logic [WORD_W:0]     cw;
    logic [CW-1:0]       count_m1;
    logic [IW-1:0]       last_ix;
    logic [IW-1:0]       count_ix;
    logic                full;
    logic                rsp_free;
    logic                rsp_load;
    logic                word_end;
    logic                emit_end;

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_load  = rsp_free && ((state_reg == S_LOUT) || (state_reg == S_RESP));

    assign count_m1  = count_reg - CW'(1);
    assign last_ix   = IW'(count_m1);
    assign count_ix  = IW'(count_reg);
    assign full      = (count_reg == CW'(TABLE_ENTRIES));
    assign word_end  = (word_reg == WIW'(VALUE_WORDS - 1));
    assign emit_end  = (word_reg == WIW'(EW - 1));

    // ---- cell chain ----
    assign tok[0] = '{valid: start_reg, found: 1'b0, idx: '0};

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        skv_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .key     (key_reg),
            .live    (CW'(i) < count_reg),
            .wr_en   (cell_we[i]),
            .wr_name (cell_wdata),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .name    (cell_name[i])
        );
    end

    always_comb
    begin
        cell_we    = '0;
        cell_wdata = (op_reg == OP_ADD) ? key_reg : cell_name[last_ix];
        if (state_reg == S_ACT)
        begin
            if (op_reg == OP_ADD && !hit_found_reg && !full)
                cell_we[count_ix] = 1'b1;
            else if (op_reg == OP_REMOVE && hit_found_reg)
                cell_we[hit_idx_reg] = 1'b1;
        end
    end

    // ---- value RAM ----
    assign cw        = canon_word(staged_reg[word_reg], ended_reg, word_end);
    assign ram_we    = (state_reg == S_COPY) || (state_reg == S_MWR);
    assign ram_wdata = (state_reg == S_COPY) ? cw[WORD_W-1:0] : ram_rdata;
    assign ram_waddr = AW'(int'(dst_reg) * VALUE_WORDS + int'(word_reg));
    assign ram_raddr = AW'(int'(src_reg) * VALUE_WORDS + int'(word_reg));

    skv_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---- sequencer ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            for (int k = 0; k < VALUE_WORDS; k++)
                staged_reg[k] <= '0;
            key_reg       <= '0;
            op_reg        <= OP_ADD;
            start_reg     <= 1'b0;
            hit_found_reg <= 1'b0;
            hit_idx_reg   <= '0;
            dst_reg       <= '0;
            src_reg       <= '0;
            word_reg      <= '0;
            ended_reg     <= 1'b0;
            status_reg    <= ST_OK;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (rsp_ready && !rsp_load)
                rsp_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        key_reg <= canon_name(cmd.name_lo, cmd.name_hi);
                        op_reg  <= cmd.opcode;
                        case (cmd.opcode)
                            OP_ADD:
                            begin
                                if (32'(cmd.word_index) < VALUE_WORDS)
                                    staged_reg[WIW'(cmd.word_index)] <= cmd.value_word;
                                start_reg <= cmd.last_word;
                                if (cmd.last_word)
                                    state_reg <= S_SEARCH;
                            end
                            OP_REMOVE, OP_LOOKUP:
                            begin
                                start_reg <= 1'b1;
                                state_reg <= S_SEARCH;
                            end
                            default: ;
                        endcase
                    end
                end

                S_SEARCH:
                begin
                    start_reg <= 1'b0;
                    if (tok[TABLE_ENTRIES].valid)
                    begin
                        hit_found_reg <= tok[TABLE_ENTRIES].found;
                        hit_idx_reg   <= IW'(tok[TABLE_ENTRIES].idx);
                        state_reg     <= S_ACT;
                    end
                end

                S_ACT:
                begin
                    word_reg  <= '0;
                    ended_reg <= 1'b0;
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (hit_found_reg)
                            begin
                                dst_reg   <= hit_idx_reg;
                                state_reg <= S_COPY;
                            end
                            else if (full)
                            begin
                                for (int k = 0; k < VALUE_WORDS; k++)
                                    staged_reg[k] <= '0;
                                status_reg <= ST_FULL;
                                state_reg  <= S_RESP;
                            end
                            else
                            begin
                                dst_reg   <= count_ix;
                                count_reg <= count_reg + CW'(1);
                                state_reg <= S_COPY;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!hit_found_reg)
                            begin
                                status_reg <= ST_NOT_FOUND;
                                state_reg  <= S_RESP;
                            end
                            else
                            begin
                                count_reg  <= count_m1;
                                status_reg <= ST_OK;
                                src_reg    <= last_ix;
                                dst_reg    <= hit_idx_reg;
                                // removing the last entry needs no move
                                state_reg  <= (hit_idx_reg != last_ix) ? S_MRD : S_RESP;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (!hit_found_reg)
                            begin
                                status_reg <= ST_NOT_FOUND;
                                state_reg  <= S_RESP;
                            end
                            else
                            begin
                                src_reg   <= hit_idx_reg;
                                state_reg <= S_LRD;
                            end
                        end
                        default: state_reg <= S_IDLE;
                    endcase
                end

                S_COPY:
                begin
                    ended_reg <= cw[WORD_W];
                    if (word_end)
                    begin
                        for (int k = 0; k < VALUE_WORDS; k++)
                            staged_reg[k] <= '0;
                        status_reg <= ST_OK;
                        state_reg  <= S_RESP;
                    end
                    else
                        word_reg <= word_reg + WIW'(1);
                end

                S_MRD:
                    state_reg <= S_MWR;

                S_MWR:
                begin
                    if (word_end)
                        state_reg <= S_RESP;
                    else
                    begin
                        word_reg  <= word_reg + WIW'(1);
                        state_reg <= S_MRD;
                    end
                end

                S_LRD:
                    state_reg <= S_LOUT;

                S_LOUT:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg       <= 1'b1;
                        rsp_reg.status      <= ST_OK;
                        rsp_reg.data_word   <= ram_rdata;
                        rsp_reg.data_index  <= 3'(word_reg);
                        rsp_reg.last        <= emit_end;
                        rsp_reg.entry_count <= 4'(count_reg);
                        if (emit_end)
                            state_reg <= S_IDLE;
                        else
                        begin
                            word_reg  <= word_reg + WIW'(1);
                            state_reg <= S_LRD;
                        end
                    end
                end

                S_RESP:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg       <= 1'b1;
                        rsp_reg.status      <= status_reg;
                        rsp_reg.data_word   <= '0;
                        rsp_reg.data_index  <= '0;
                        rsp_reg.last        <= 1'b1;
                        rsp_reg.entry_count <= 4'(count_reg);
                        state_reg           <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // ---- checks ----
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_ENTRIES))
        else $error("entry count above table size");

    a_count_from_act: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_ACT))
        else $error("entry count changed outside decision step");

    a_token_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        tok[TABLE_ENTRIES].valid |-> (state_reg == S_SEARCH))
        else $error("search token left chain outside search");

    a_partial_only_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.last) |-> (op_reg == OP_LOOKUP))
        else $error("non-final item from a non-lookup command");

    a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MWR) |-> ($past(state_reg) == S_MRD))
        else $error("entry move wrote without a read");

endmodule

`default_nettype wire

/* bench/tb.sv */
// Testbench for string_key_value_table: directed and random add/remove/lookup
// traffic, checked against an in-bench model of the table. Needs skv_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import skv_pkg::*;

    localparam int ENTRIES = 8;
    localparam int WORDS   = 8;
    localparam int STALL_LIMIT = 20000;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_ready;
    in_item_t  cmd;
    logic      rsp_valid;
    logic      rsp_ready;
    out_item_t rsp;

    string_key_value_table dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    // table model
    logic [NAME_W-1:0] tbl_names [ENTRIES];
    logic [63:0]       tbl_values [ENTRIES][WORDS];
    int                tbl_used;
    logic [63:0]       staging [WORDS];

    out_item_t expected_rsp [$];
    int        error_count;
    int        idle_cycles;
    bit        no_gaps;
    bit        hold_rsp;
    bit        done;

    // small pool of names so hits are common
    logic [63:0] pool_lo [12];
    logic [55:0] pool_hi [12];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [NAME_W-1:0] key_of(input logic [63:0] lo, input logic [55:0] hi);
        logic [NAME_W-1:0] raw;
        logic [NAME_W-1:0] k;
        k   = '0;
        raw = {hi, lo};
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            if (raw[i*8 +: 8] == 8'h00)
                break;
            k[i*8 +: 8] = raw[i*8 +: 8];
        end
        return k;
    endfunction

    function automatic int find_key(input logic [NAME_W-1:0] k);
        for (int i = 0; i < tbl_used; i++)
            if (tbl_names[i] == k)
                return i;
        return -1;
    endfunction

    function automatic out_item_t mk_rsp(input logic [1:0] st, input logic [63:0] d,
                                         input logic [2:0] idx, input logic lst);
        out_item_t r;
        r.status      = st;
        r.data_word   = d;
        r.data_index  = idx;
        r.last        = lst;
        r.entry_count = tbl_used[3:0];
        return r;
    endfunction

    task automatic predict_table(input in_item_t it);
        logic [NAME_W-1:0] k;
        logic [1:0]        st;
        bit                ended;
        int                hit;
        k   = key_of(it.name_lo, it.name_hi);
        hit = find_key(k);
        case (it.opcode)
            OP_ADD:
            begin
                staging[it.word_index] = it.value_word;
                if (it.last_word)
                begin
                    staging[WORDS-1][63:56] = 8'h00;
                    ended = 0;
                    for (int w = 0; w < WORDS; w++)
                        for (int b = 0; b < 8; b++)
                            if (ended)
                                staging[w][b*8 +: 8] = 8'h00;
                            else if (staging[w][b*8 +: 8] == 8'h00)
                                ended = 1;
                    st = ST_OK;
                    if (hit >= 0)
                        tbl_values[hit] = staging;
                    else if (tbl_used >= ENTRIES)
                        st = ST_FULL;
                    else
                    begin
                        tbl_names[tbl_used]  = k;
                        tbl_values[tbl_used] = staging;
                        tbl_used++;
                    end
                    foreach (staging[w])
                        staging[w] = '0;
                    expected_rsp.push_back(mk_rsp(st, '0, '0, 1'b1));
                end
            end
            OP_REMOVE:
            begin
                if (hit < 0)
                    expected_rsp.push_back(mk_rsp(ST_NOT_FOUND, '0, '0, 1'b1));
                else
                begin
                    tbl_used--;
                    tbl_names[hit]  = tbl_names[tbl_used];
                    tbl_values[hit] = tbl_values[tbl_used];
                    expected_rsp.push_back(mk_rsp(ST_OK, '0, '0, 1'b1));
                end
            end
            OP_LOOKUP:
            begin
                if (hit < 0)
                    expected_rsp.push_back(mk_rsp(ST_NOT_FOUND, '0, '0, 1'b1));
                else
                    for (int w = 0; w < WORDS; w++)
                        expected_rsp.push_back(mk_rsp(ST_OK, tbl_values[hit][w], w[2:0],
                                                      w == WORDS - 1));
            end
            default: ;
        endcase
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // valid stays high after acceptance; the next call or wait_drain takes it down
    task automatic send_item(input in_item_t it);
        while (!no_gaps && $urandom_range(99) < 32)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd       <= it;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        predict_table(it);
    endtask

    function automatic in_item_t mk_cmd(input logic [1:0] op, input int nm,
                                        input logic [63:0] v, input logic [2:0] wi,
                                        input logic lw);
        in_item_t it;
        it.opcode     = op;
        it.name_lo    = pool_lo[nm];
        it.name_hi    = pool_hi[nm];
        it.value_word = v;
        it.word_index = wi;
        it.last_word  = lw;
        return it;
    endfunction

    function automatic logic [63:0] rand_word();
        logic [63:0] v;
        v = {$urandom, $urandom};
        // often put a terminator somewhere inside
        if ($urandom_range(2) == 0)
            v[$urandom_range(7)*8 +: 8] = 8'h00;
        return v;
    endfunction

    task automatic add_value(input int nm, input int nwords);
        for (int w = 0; w < nwords; w++)
            send_item(mk_cmd(OP_ADD, nm, rand_word(), w[2:0], w == nwords - 1));
    endtask

    task automatic wait_drain();
        cmd_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        in_item_t it;
        send_item(mk_cmd(OP_LOOKUP, 0, '0, '0, 1'b0));         // empty lookup
        send_item(mk_cmd(OP_REMOVE, 0, '0, '0, 1'b0));         // empty remove
        send_item(mk_cmd(OP_ADD, 0, '1, 3'd7, 1'b1));          // final byte forced zero
        send_item(mk_cmd(OP_LOOKUP, 0, '0, '0, 1'b0));
        send_item(mk_cmd(OP_ADD, 1, 64'h0000_0000_0000_0041, 3'd0, 1'b0));
        send_item(mk_cmd(OP_ADD, 1, '1, 3'd1, 1'b0));           // after terminator
        send_item(mk_cmd(OP_LOOKUP, 1, '0, '0, 1'b0));          // lookup mid add
        send_item(mk_cmd(OP_ADD, 1, '1, 3'd2, 1'b1));
        send_item(mk_cmd(OP_LOOKUP, 1, '0, '0, 1'b0));
        // lookup of a name with junk after its terminator
        it = mk_cmd(OP_LOOKUP, 2, '0, '0, 1'b0);
        it.name_lo = 64'hFFFF_0000_0000_4142;
        it.name_hi = '1;
        send_item(it);
        it.name_lo = '1;                                     // full 15-byte name
        it.opcode  = OP_ADD;
        it.last_word = 1'b1;
        it.value_word = '1;
        send_item(it);
        it.opcode = OP_LOOKUP;
        send_item(it);
        it.opcode = 2'd3;                                    // ignored opcode
        send_item(it);
        for (int n = 3; n < 9; n++)
            add_value(n, 1);
        send_item(mk_cmd(OP_ADD, 9, 64'h55, 3'd0, 1'b1));       // full
        send_item(mk_cmd(OP_REMOVE, 0, '0, '0, 1'b0));          // moves last entry
        send_item(mk_cmd(OP_LOOKUP, 8, '0, '0, 1'b0));
        wait_drain();
    endtask

    task automatic test_random(input int count);
        int n;
        int r;
        int nw;
        n = 0;
        while (n < count)
        begin
            r = $urandom_range(99);
            if (r < 45)
            begin
                nw = $urandom_range(1, 3);
                add_value($urandom_range(11), nw);
                n += nw - 1;
            end
            else if (r < 65)
                send_item(mk_cmd(OP_REMOVE, $urandom_range(11), '0, '0, 1'b0));
            else if (r < 95)
                send_item(mk_cmd(OP_LOOKUP, $urandom_range(11), '0, '0, 1'b0));
            else
                send_item(mk_cmd(2'($urandom_range(3)), $urandom_range(11), rand_word(),
                                 3'($urandom_range(7)), 1'($urandom_range(1))));
            n++;
        end
        wait_drain();
    endtask

    task automatic test_backpressure();
        hold_rsp = 1;
        no_gaps  = 1;
        for (int i = 0; i < 6; i++)
            send_item(mk_cmd(OP_LOOKUP, $urandom_range(11), '0, '0, 1'b0));
        no_gaps  = 0;
        wait_drain();
    endtask

    task automatic test_no_gaps();
        no_gaps = 1;
        test_random(25);
        no_gaps = 0;
    endtask

    // receiver: random stalls, checks each item against the oldest expectation
    always @(posedge clk)
    begin
        out_item_t w;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
                report("unexpected item", rsp.data_word, '0);
            else
            begin
                w = expected_rsp.pop_front();
                if (rsp.status != w.status)
                    report("status", 64'(rsp.status), 64'(w.status));
                if (rsp.data_word != w.data_word)
                    report("data_word", rsp.data_word, w.data_word);
                if (rsp.data_index != w.data_index)
                    report("data_index", 64'(rsp.data_index), 64'(w.data_index));
                if (rsp.last != w.last)
                    report("last", 64'(rsp.last), 64'(w.last));
                if (rsp.entry_count != w.entry_count)
                    report("entry_count", 64'(rsp.entry_count), 64'(w.entry_count));
            end
        end
        rsp_ready <= !hold_rsp && (no_gaps || $urandom_range(99) >= 32);
    end

    // long receiver hold-off while the sender keeps pushing
    initial
    begin
        @(posedge hold_rsp);
        repeat (400)
            @(posedge clk);
        hold_rsp = 0;
    end

    // watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || hold_rsp)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !done)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        cmd         = '0;
        rsp_ready   = 1'b0;
        tbl_used    = 0;
        error_count = 0;
        idle_cycles = 0;
        no_gaps     = 0;
        hold_rsp    = 0;
        done        = 0;
        foreach (staging[w])
            staging[w] = '0;
        foreach (pool_lo[i])
        begin
            pool_lo[i] = {$urandom, $urandom} | 64'h0101_0101_0101_0101;
            pool_hi[i] = 56'({$urandom, $urandom});
            if (i % 3 == 0)
                pool_lo[i][$urandom_range(7)*8 +: 8] = 8'h00;   // short names
        end
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(115);
        test_backpressure();
        test_no_gaps();
        wait_drain();
        repeat (200)
            @(posedge clk);
        done = 1;
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

/* filelist.f */
sv/skv_pkg.sv
sv/skv_ram.sv
sv/skv_cell.sv
sv/string_key_value_table.sv
bench/tb.sv
